FILE: rtl/pcrc_pkg.sv
// Shared types, constants and the CRC-16/CCITT byte update for the packet checker.
`default_nettype none

package pcrc_pkg;

    localparam int unsigned MAX_PACKET_BYTES_DEF = 2048;

    localparam logic [15:0] CRC_INIT = 16'hFFFF;
    localparam logic [15:0] CRC_POLY = 16'h1021;
    localparam logic [15:0] CRC_TOP  = 16'h8000;

    localparam int unsigned CFG_W   = 9;
    localparam int unsigned COUNT_W = 32;
    localparam int unsigned OUT_W   = 104;

    typedef enum logic [1:0] {
        VERDICT_OK    = 2'd0,
        VERDICT_CRC   = 2'd1,
        VERDICT_SHAPE = 2'd2
    } verdict_t;

    // one accepted input request, as held in the input register
    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
    } byte_req_t;

    // MSB-first CRC-16, eight bit steps unrolled
    function automatic logic [15:0] crc_feed(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {b, 8'h00};
        for (int i = 0; i < 8; i++) begin
            if ((c & CRC_TOP) != 16'h0000) begin
                c = {c[14:0], 1'b0} ^ CRC_POLY;
            end else begin
                c = {c[14:0], 1'b0};
            end
        end
        return c;
    endfunction

endpackage

`default_nettype wire

FILE: rtl/pcrc_frame_check.sv
// Per-packet state: trailer delay line, running CRC, byte count and verdict logic.
`default_nettype none

module pcrc_frame_check #(
    parameter int unsigned MAX_PACKET_BYTES = pcrc_pkg::MAX_PACKET_BYTES_DEF
) (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      step,
    input  wire pcrc_pkg::byte_req_t       req,
    input  wire logic [pcrc_pkg::CFG_W-1:0] expected_value_count,
    output pcrc_pkg::verdict_t             verdict
);
    import pcrc_pkg::*;

    // count saturates at MAX_PACKET_BYTES + 1
    localparam int unsigned CW   = $clog2(MAX_PACKET_BYTES + 2);
    localparam int unsigned LENW = CFG_W + 2;
    localparam int unsigned CMPW = (CW > LENW) ? CW : LENW;

    logic [15:0]   crc_reg, crc_next;
    logic [7:0]    held0_reg, held0_next;
    logic [7:0]    held1_reg, held1_next;
    logic [CW-1:0] count_reg, count_next;

    logic [15:0]   crc_fed;
    logic [CW-1:0] count_inc;
    logic [15:0]   trailer;
    logic [CMPW-1:0] len_seen;
    logic [CMPW-1:0] len_want;

    always_comb
    begin
        crc_fed   = (count_reg >= CW'(2)) ? crc_feed(crc_reg, held0_reg) : crc_reg;
        count_inc = (count_reg <= CW'(MAX_PACKET_BYTES)) ? count_reg + CW'(1) : count_reg;
        // trailer is low byte first: older held byte, then the byte at hand
        trailer   = {req.data_byte, held1_reg};
        len_seen  = CMPW'(count_inc);
        // 4 * count + 2 trailer bytes
        len_want  = CMPW'({expected_value_count, 2'b10});

        if (count_inc < CW'(2) || count_inc > CW'(MAX_PACKET_BYTES)) begin
            verdict = VERDICT_SHAPE;
        end else if (crc_fed != trailer) begin
            verdict = VERDICT_CRC;
        end else if (len_seen != len_want) begin
            verdict = VERDICT_SHAPE;
        end else begin
            verdict = VERDICT_OK;
        end

        crc_next   = crc_reg;
        held0_next = held0_reg;
        held1_next = held1_reg;
        count_next = count_reg;
        if (step) begin
            if (req.last_byte) begin
                crc_next   = CRC_INIT;
                held0_next = 8'h00;
                held1_next = 8'h00;
                count_next = '0;
            end else begin
                crc_next   = crc_fed;
                held0_next = held1_reg;
                held1_next = req.data_byte;
                count_next = count_inc;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            crc_reg   <= CRC_INIT;
            held0_reg <= 8'h00;
            held1_reg <= 8'h00;
            count_reg <= '0;
        end else begin
            crc_reg   <= crc_next;
            held0_reg <= held0_next;
            held1_reg <= held1_next;
            count_reg <= count_next;
        end
    end

endmodule

`default_nettype wire

FILE: rtl/packet_crc16_length_checker_top.sv
// Top level of the datagram CRC-16 and length checker.
//
// Usage:
//   s_axis carries one datagram byte per request in tdata[7:0]; tlast marks
//   the final byte. Every byte is taken; only the final byte produces a result.
//   m_axis carries one result per datagram: verdict (0 ok, 1 crc, 2 shape)
//   and the three wrapping packet totals including this packet.
//   cfg_wr_en / cfg_wr_data load expected_value_count (four-byte values per
//   payload); write it only while no packet is in flight.
// Timing:
//   One byte per cycle, but a final byte waits while a result is stalled. A
//   byte goes into an input register, then the CRC/length logic (one unrolled
//   8-step CRC update) loads the result register as the last byte leaves the
//   input register, when totals and per-packet state update too.
// Reset:
//   rst_n clears the CRC to 0xFFFF, the delay line, byte count, totals and the
//   register; no sweep is needed, bytes are taken right after reset.
// Stall:
//   While a result waits on m_axis_tready, non-final bytes keep flowing; a
//   second final byte waits in the input register, holding s_axis_tready low.
`default_nettype none

module packet_crc16_length_checker_top #(
    parameter int unsigned MAX_PACKET_BYTES = pcrc_pkg::MAX_PACKET_BYTES_DEF
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        s_axis_tvalid,
    output logic                             s_axis_tready,
    input  wire logic [7:0]                  s_axis_tdata,   // [7:0] data_byte
    input  wire logic                        s_axis_tlast,   // last_byte
    output logic                             m_axis_tvalid,
    input  wire logic                        m_axis_tready,
    // [1:0] verdict, [33:2] accepted_count, [65:34] corrupted_count,
    // [97:66] invalid_count, [103:98] zero
    output logic [pcrc_pkg::OUT_W-1:0]       m_axis_tdata,
    input  wire logic                        cfg_wr_en,
    input  wire logic [pcrc_pkg::CFG_W-1:0]  cfg_wr_data
);
    import pcrc_pkg::*;

    localparam int unsigned PAD_W = OUT_W - 2 - 3 * COUNT_W;

    logic                 in_valid_reg, in_valid_next;
    byte_req_t            in_req_reg;
    logic [CFG_W-1:0]     evc_reg;
    logic [COUNT_W-1:0]   acc_total_reg, acc_total_next;
    logic [COUNT_W-1:0]   crc_total_reg, crc_total_next;
    logic [COUNT_W-1:0]   inv_total_reg, inv_total_next;
    logic                 out_valid_reg, out_valid_next;
    verdict_t             out_verdict_reg;

    logic     advance;
    logic     finish;
    verdict_t verdict;

    // non-final bytes never need the result slot
    assign advance = in_valid_reg &&
                     (!in_req_reg.last_byte || !out_valid_reg || m_axis_tready);
    assign finish  = advance && in_req_reg.last_byte;

    assign s_axis_tready = !in_valid_reg || advance;
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {PAD_W'(0), inv_total_reg, crc_total_reg, acc_total_reg,
                            out_verdict_reg};

    pcrc_frame_check #(
        .MAX_PACKET_BYTES (MAX_PACKET_BYTES)
    ) u_frame (
        .clk                  (clk),
        .rst_n                (rst_n),
        .step                 (advance),
        .req                  (in_req_reg),
        .expected_value_count (evc_reg),
        .verdict              (verdict)
    );

    always_comb
    begin
        in_valid_next = s_axis_tready ? s_axis_tvalid : in_valid_reg;

        acc_total_next = acc_total_reg;
        crc_total_next = crc_total_reg;
        inv_total_next = inv_total_reg;
        if (finish) begin
            case (verdict)
                VERDICT_OK:  acc_total_next = acc_total_reg + COUNT_W'(1);
                VERDICT_CRC: crc_total_next = crc_total_reg + COUNT_W'(1);
                default:     inv_total_next = inv_total_reg + COUNT_W'(1);
            endcase
        end

        if (finish) begin
            out_valid_next = 1'b1;
        end else if (m_axis_tready) begin
            out_valid_next = 1'b0;
        end else begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            evc_reg       <= '0;
            acc_total_reg <= '0;
            crc_total_reg <= '0;
            inv_total_reg <= '0;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
            acc_total_reg <= acc_total_next;
            crc_total_reg <= crc_total_next;
            inv_total_reg <= inv_total_next;
            if (cfg_wr_en) begin
                evc_reg <= cfg_wr_data;
            end
        end
    end

    // payload registers, no reset
    always_ff @(posedge clk)
    begin
        if (s_axis_tready && s_axis_tvalid) begin
            in_req_reg <= '{data_byte: s_axis_tdata, last_byte: s_axis_tlast};
        end
        if (finish) begin
            out_verdict_reg <= verdict;
        end
    end

endmodule

`default_nettype wire

FILE: rtl/pcrc_checker.sv
// Port-level assertions for the packet checker, bound to the top level.
`default_nettype none

module pcrc_checker (
    input wire logic         clk,
    input wire logic         rst_n,
    input wire logic         s_axis_tready,
    input wire logic         m_axis_tvalid,
    input wire logic         m_axis_tready,
    input wire logic [103:0] m_axis_tdata
);
    import pcrc_pkg::*;

    // a stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result changed while stalled");

    a_verdict_code: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |->
            m_axis_tdata[1:0] == VERDICT_OK ||
            m_axis_tdata[1:0] == VERDICT_CRC ||
            m_axis_tdata[1:0] == VERDICT_SHAPE)
        else $error("undefined verdict code");

    // the total matching the verdict includes this packet
    a_total_counts: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |->
            (m_axis_tdata[1:0] == VERDICT_OK && m_axis_tdata[33:2] != 32'd0) ||
            (m_axis_tdata[1:0] == VERDICT_CRC && m_axis_tdata[65:34] != 32'd0) ||
            (m_axis_tdata[1:0] == VERDICT_SHAPE && m_axis_tdata[97:66] != 32'd0))
        else $error("total not bumped for verdict");

    a_pad_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> m_axis_tdata[103:98] == 6'd0)
        else $error("padding bits set");

    // input only backs up behind a stalled result
    a_ready_stall: assert property (@(posedge clk) disable iff (!rst_n)
        !s_axis_tready |-> m_axis_tvalid && !m_axis_tready)
        else $error("input blocked without a stalled result");

endmodule

bind packet_crc16_length_checker_top pcrc_checker u_pcrc_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

`default_nettype wire

FILE: verif/testbench.sv
// Self-checking testbench for the datagram CRC-16 and length checker.
module testbench;
    import pcrc_pkg::*;

    localparam int unsigned MAX_BYTES    = MAX_PACKET_BYTES_DEF;
    localparam int unsigned RANDOM_BYTES = 1450;
    localparam int unsigned CFG_SETTLE   = 4;
    localparam int unsigned DRAIN_CYCLES = 12;
    localparam int unsigned PAD_LSB      = 2 + 3 * COUNT_W;
    localparam longint unsigned CYCLE_LIMIT = 4_000_000;

    typedef struct packed {
        verdict_t           verdict;
        logic [COUNT_W-1:0] accepted;
        logic [COUNT_W-1:0] corrupted;
        logic [COUNT_W-1:0] invalid;
    } packet_verdict_t;

    logic             clk;
    logic             rst_n;
    logic             s_axis_tvalid;
    wire              s_axis_tready;
    logic [7:0]       s_axis_tdata;     // [7:0] data_byte
    logic             s_axis_tlast;     // last_byte
    wire              m_axis_tvalid;
    logic             m_axis_tready = 1'b1;
    // [1:0] verdict, [33:2] accepted, [65:34] corrupted, [97:66] invalid, rest zero
    wire [OUT_W-1:0]  m_axis_tdata;
    logic             cfg_wr_en;
    logic [CFG_W-1:0] cfg_wr_data;

    // checker model state
    logic [CFG_W-1:0]   model_value_count;
    logic [15:0]        model_crc;
    logic [7:0]         model_delay [0:1];
    int unsigned        model_len;
    logic [COUNT_W-1:0] model_accepted;
    logic [COUNT_W-1:0] model_corrupted;
    logic [COUNT_W-1:0] model_invalid;

    packet_verdict_t expected_verdicts [$];
    logic [7:0]      frame_bytes [$];

    int          errors = 0;
    int          results_seen = 0;
    int unsigned bytes_sent = 0;
    int          stall_left = 0;
    bit          tx_gaps_on = 1'b1;
    bit          rx_stalls_on = 1'b1;
    longint unsigned cycle_count = 0;

    packet_crc16_length_checker_top u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d results pending",
                     cycle_count, expected_verdicts.size());
            $display("DONE: errors detected");
            $finish;
        end
    end

    // mostly short gaps, a few long ones
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        else if (r < 85)
            return $urandom_range(1, 3);
        else if (r < 97)
            return $urandom_range(4, 12);
        else
            return $urandom_range(20, 60);
    endfunction

    function automatic logic [15:0] crc16_step(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] acc;
        logic        fb;
        acc = crc;
        for (int i = 7; i >= 0; i--)
        begin
            fb  = acc[15] ^ b[i];
            acc = {acc[14:0], 1'b0};
            if (fb)
                acc = acc ^ CRC_POLY;
        end
        return acc;
    endfunction

    function automatic logic [7:0] pick_byte();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0)
            return 8'h00;
        else if (r == 1)
            return 8'hFF;
        else
            return 8'($urandom_range(0, 255));
    endfunction

    task automatic clear_packet_state();
        model_crc      = CRC_INIT;
        model_delay[0] = 8'h00;
        model_delay[1] = 8'h00;
        model_len      = 0;
    endtask

    task automatic reset_model();
        model_value_count = '0;
        model_accepted    = '0;
        model_corrupted   = '0;
        model_invalid     = '0;
        clear_packet_state();
    endtask

    task automatic predict_byte(input logic [7:0] data, input logic last);
        packet_verdict_t rec;
        logic [15:0]     trailer;
        // the two newest bytes stay out of the CRC until proven not to be trailer
        if (model_len >= 2)
            model_crc = crc16_step(model_crc, model_delay[0]);
        model_delay[0] = model_delay[1];
        model_delay[1] = data;
        if (model_len <= MAX_BYTES)
            model_len++;
        if (last)
        begin
            trailer = {model_delay[1], model_delay[0]};
            if (model_len < 2 || model_len > MAX_BYTES)
                rec.verdict = VERDICT_SHAPE;
            else if (model_crc != trailer)
                rec.verdict = VERDICT_CRC;
            else if (model_len - 2 != 4 * int'(model_value_count))
                rec.verdict = VERDICT_SHAPE;
            else
                rec.verdict = VERDICT_OK;
            case (rec.verdict)
                VERDICT_OK:  model_accepted++;
                VERDICT_CRC: model_corrupted++;
                default:     model_invalid++;
            endcase
            rec.accepted  = model_accepted;
            rec.corrupted = model_corrupted;
            rec.invalid   = model_invalid;
            expected_verdicts.push_back(rec);
            clear_packet_state();
        end
    endtask

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        errors++;
        if (errors <= 40)
            $display("MISMATCH %s: got %0h, expected %0h (cycle %0d)",
                     what, got, want, cycle_count);
    endtask

    always @(posedge clk)
    begin : check_results
        packet_verdict_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            results_seen++;
            if (expected_verdicts.size() == 0)
            begin
                report_mismatch("result with none pending", 64'(m_axis_tdata[1:0]), 64'd0);
            end
            else
            begin
                want = expected_verdicts.pop_front();
                if (m_axis_tdata[1:0] !== want.verdict)
                    report_mismatch("verdict", 64'(m_axis_tdata[1:0]), 64'(want.verdict));
                if (m_axis_tdata[2 +: COUNT_W] !== want.accepted)
                    report_mismatch("accepted_count", 64'(m_axis_tdata[2 +: COUNT_W]),
                                    64'(want.accepted));
                if (m_axis_tdata[2 + COUNT_W +: COUNT_W] !== want.corrupted)
                    report_mismatch("corrupted_count",
                                    64'(m_axis_tdata[2 + COUNT_W +: COUNT_W]),
                                    64'(want.corrupted));
                if (m_axis_tdata[2 + 2 * COUNT_W +: COUNT_W] !== want.invalid)
                    report_mismatch("invalid_count",
                                    64'(m_axis_tdata[2 + 2 * COUNT_W +: COUNT_W]),
                                    64'(want.invalid));
                if (m_axis_tdata[OUT_W-1:PAD_LSB] !== '0)
                    report_mismatch("pad bits", 64'(m_axis_tdata[OUT_W-1:PAD_LSB]), 64'd0);
            end
        end
    end

    // receiver side back-pressure
    always @(posedge clk)
    begin
        if (stall_left > 0)
        begin
            m_axis_tready <= 1'b0;
            stall_left    <= stall_left - 1;
        end
        else
        begin
            m_axis_tready <= 1'b1;
            if (rx_stalls_on && $urandom_range(0, 3) == 0)
                stall_left <= pick_gap() + 1;
        end
    end

    task automatic send_byte(input logic [7:0] data, input logic last);
        int gap;
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= data;
        s_axis_tlast  <= last;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        predict_byte(data, last);
        bytes_sent++;
        gap = tx_gaps_on ? pick_gap() : 0;
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic send_frame();
        for (int i = 0; i < frame_bytes.size(); i++)
            send_byte(frame_bytes[i], i == frame_bytes.size() - 1);
    endtask

    // payload plus little-endian CRC trailer; a bad CRC flips one bit anywhere
    task automatic build_frame(input int payload_len, input bit good_crc);
        logic [15:0] crc;
        int          pos;
        frame_bytes.delete();
        crc = CRC_INIT;
        for (int i = 0; i < payload_len; i++)
        begin
            frame_bytes.push_back(pick_byte());
            crc = crc16_step(crc, frame_bytes[i]);
        end
        frame_bytes.push_back(crc[7:0]);
        frame_bytes.push_back(crc[15:8]);
        if (!good_crc)
        begin
            pos = $urandom_range(0, frame_bytes.size() - 1);
            frame_bytes[pos] = frame_bytes[pos] ^ (8'h01 << $urandom_range(0, 7));
        end
    endtask

    task automatic build_noise(input int len);
        frame_bytes.delete();
        for (int i = 0; i < len; i++)
            frame_bytes.push_back(pick_byte());
    endtask

    // register writes only between packets, with nothing in flight
    task automatic configure(input logic [CFG_W-1:0] value);
        s_axis_tvalid <= 1'b0;
        while (expected_verdicts.size() != 0)
            @(posedge clk);
        repeat (CFG_SETTLE) @(posedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        model_value_count = value;
    endtask

    task automatic test_empty_payload();
        // value count is zero out of reset, so a bare trailer is a good packet
        build_frame(0, 1'b1);
        send_frame();
        build_frame(0, 1'b0);
        send_frame();
        build_noise(2);
        frame_bytes[0] = 8'h00;
        frame_bytes[1] = 8'h00;
        send_frame();
    endtask

    task automatic test_single_byte();
        tx_gaps_on = 1'b0;
        send_byte(8'h00, 1'b1);
        send_byte(8'hFF, 1'b1);
        send_byte(pick_byte(), 1'b1);
        tx_gaps_on = 1'b1;
        send_byte(8'h5A, 1'b1);
    endtask

    task automatic test_crc_mismatch();
        configure(CFG_W'(1));
        build_frame(4, 1'b1);
        send_frame();
        repeat (6)
        begin
            build_frame(4, 1'b0);
            send_frame();
        end
    endtask

    task automatic test_length_mismatch();
        configure(CFG_W'(3));
        build_frame(11, 1'b1);
        send_frame();
        build_frame(13, 1'b1);
        send_frame();
        build_frame(0, 1'b1);
        send_frame();
        build_frame(12, 1'b1);
        send_frame();
        // CRC is judged before length
        build_frame(16, 1'b0);
        send_frame();
    endtask

    task automatic test_size_extremes();
        tx_gaps_on = 1'b0;
        // widest value count: a short good frame misses the length
        configure(9'h1FF);
        build_frame(4, 1'b1);
        send_frame();
        configure('0);
        build_frame(0, 1'b1);
        send_frame();
        tx_gaps_on = 1'b1;
    endtask

    task automatic test_random_traffic();
        int unsigned start;
        int          pkts;
        int          kind;
        int          len;
        logic [CFG_W-1:0] value;
        start = bytes_sent;
        pkts  = 0;
        while (bytes_sent - start < RANDOM_BYTES)
        begin
            if (pkts % 16 == 0)
            begin
                tx_gaps_on   = $urandom_range(0, 3) != 0;
                rx_stalls_on = $urandom_range(0, 3) != 0;
                kind = $urandom_range(0, 9);
                if (kind == 0)
                    value = '0;
                else if (kind < 8)
                    value = CFG_W'($urandom_range(1, 6));
                else
                    value = CFG_W'($urandom_range(7, 20));
                configure(value);
            end
            kind = $urandom_range(0, 99);
            if (kind < 65)
            begin
                build_frame(4 * int'(model_value_count), 1'b1);
            end
            else if (kind < 77)
            begin
                build_frame(4 * int'(model_value_count), 1'b0);
            end
            else if (kind < 89)
            begin
                len = 4 * int'(model_value_count) + $urandom_range(0, 4) - 2;
                build_frame(len < 0 ? 0 : len, 1'b1);
            end
            else
            begin
                build_noise($urandom_range(1, 24));
            end
            send_frame();
            pkts++;
        end
    endtask

    initial
    begin
        rst_n         = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = 8'h00;
        s_axis_tlast  = 1'b0;
        cfg_wr_en     = 1'b0;
        cfg_wr_data   = '0;
        reset_model();
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        test_empty_payload();
        test_single_byte();
        test_crc_mismatch();
        test_length_mismatch();
        test_size_extremes();
        test_random_traffic();

        s_axis_tvalid <= 1'b0;
        while (expected_verdicts.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Sent %0d bytes, checked %0d packet verdicts", bytes_sent, results_seen);
        $display("Totals: %0d accepted, %0d crc corrupted, %0d shape invalid",
                 model_accepted, model_corrupted, model_invalid);
        if (errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
